// ===== rtl/core/ptmw_pkg.sv =====
`default_nettype none

package ptmw_pkg;

    localparam int PG_SHIFT  = 12;
    localparam int IDX_W     = 9;
    localparam int TBL_ENTRIES = 512;
    localparam int ENTRY_W   = 64;
    localparam int VA_W      = 48;
    localparam int PA_W      = 52;
    localparam int ATTR_W    = 12;
    localparam int BASE_W    = 52;
    localparam int LIMIT_W   = 53;
    localparam int CFG_W     = 53;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIMIT   = 1'b1;

    localparam logic [BASE_W-1:0]  ALLOC_START_RST = '0;
    localparam logic [LIMIT_W-1:0] MEM_LIMIT_RST   = 53'h10_0000_0000_0000;

    localparam logic [1:0] LVL_TOP        = 2'd0;
    localparam logic [1:0] LVL_LAST_UPPER = 2'd2;
    localparam logic [1:0] LVL_LEAF       = 2'd3;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOMAP  = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic {
        MODE_MAP    = 1'b0,
        MODE_LOOKUP = 1'b1
    } t_mode;

    typedef struct packed {
        logic    start;
        logic    rd;
        logic    wr_slot;
        logic    wr_leaf;
        logic    clr_wr;
        logic    clr_root;
        logic    advance;
        logic    alloc_adv;
        logic    set_res;
        t_status res_status;
        logic    push;
    } t_cmd;

    typedef struct packed {
        t_mode      mode;
        logic [1:0] level;
        logic       e_zero;
        logic       page_ok;
        logic       alloc_ok;
        logic       clr_last;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/ptmw_if.sv =====
`default_nettype none

interface ptmw_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [11:0] attr;

    modport source (output valid, mode, virt_addr, phys_addr, attr, input ready);
    modport sink   (input valid, mode, virt_addr, phys_addr, attr, output ready);
endinterface

interface ptmw_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] entry_value;
    logic [1:0]  status;

    modport source (output valid, entry_value, status, input ready);
    modport sink   (input valid, entry_value, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ptmw_ram.sv =====
`default_nettype none

module ptmw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ptmw_ctrl.sv =====
`default_nettype none

module ptmw_ctrl
    import ptmw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_CLR_ROOT,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WR_SLOT,
        S_CLR_PAGE,
        S_WR_LEAF,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    assign o_in_ready = r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_CLR_ROOT: begin
                o_cmd.clr_wr   = 1'b1;
                o_cmd.clr_root = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.level == LVL_LEAF) begin
                    o_cmd.set_res = 1'b1;
                    n_state       = S_DONE;
                end else if (i_stat.e_zero) begin
                    if (i_stat.mode == MODE_LOOKUP) begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_NOMAP;
                        n_state          = S_DONE;
                    end else if (!i_stat.alloc_ok) begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_WR_SLOT;
                    end
                end else if (!i_stat.page_ok) begin
                    // stray pointer, walk stops here
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NOMAP;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    if (i_stat.level == LVL_LAST_UPPER && i_stat.mode == MODE_MAP) begin
                        n_state = S_WR_LEAF;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_WR_SLOT: begin
                o_cmd.wr_slot = 1'b1;
                n_state       = S_CLR_PAGE;
            end
            S_CLR_PAGE: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    o_cmd.alloc_adv = 1'b1;
                    n_state = (i_stat.level == LVL_LAST_UPPER) ? S_WR_LEAF : S_READ;
                end
            end
            S_WR_LEAF: begin
                o_cmd.wr_leaf = 1'b1;
                o_cmd.set_res = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR_ROOT;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ptmw_dpath.sv =====
`default_nettype none

module ptmw_dpath
    import ptmw_pkg::*;
#(
    parameter int POOL_PAGES = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_mode,
    input  wire logic [VA_W-1:0]        i_virt_addr,
    input  wire logic [PA_W-1:0]        i_phys_addr,
    input  wire logic [ATTR_W-1:0]      i_attr,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat,
    output logic                        o_ram_we,
    output logic [$clog2(POOL_PAGES)+IDX_W-1:0] o_ram_waddr,
    output logic [ENTRY_W-1:0]          o_ram_wdata,
    output logic                        o_ram_re,
    output logic [$clog2(POOL_PAGES)+IDX_W-1:0] o_ram_raddr,
    input  wire logic [ENTRY_W-1:0]     i_ram_rdata,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output logic [ENTRY_W-1:0]          o_out_entry,
    output logic [1:0]                  o_out_status
);

    localparam int PW   = $clog2(POOL_PAGES);
    localparam int NPW  = $clog2(POOL_PAGES + 1);
    localparam int BPW  = BASE_W - PG_SHIFT;       // page number bits of pool base
    localparam int EPW  = ENTRY_W - PG_SHIFT;      // page number bits of an entry
    localparam int APW  = BPW + 2;                 // room for base + next page + 1
    localparam int CMPW = APW + PG_SHIFT;

    logic [BASE_W-1:0]  r_alloc_start;
    logic [LIMIT_W-1:0] r_mem_limit;
    logic [NPW-1:0]     r_next_page;
    logic [PW-1:0]      r_cur;
    logic [1:0]         r_level;
    logic [IDX_W-1:0]   r_clr_idx;
    t_mode              r_mode;
    logic [VA_W-1:0]    r_va;
    logic [PA_W-1:0]    r_pa;
    logic [ATTR_W-1:0]  r_attr;
    t_status            r_res_status;
    logic [ENTRY_W-1:0] r_res_entry;
    logic               r_out_valid;
    logic [ENTRY_W-1:0] r_out_entry;
    t_status            r_out_status;

    logic [IDX_W-1:0]   lvl_idx;
    logic [BPW-1:0]     base_pg;
    logic [EPW-1:0]     diff_pg;
    logic               page_ok;
    logic [APW-1:0]     new_pg;
    logic [APW-1:0]     end_pg;
    logic               alloc_ok;
    logic [ENTRY_W-1:0] new_entry;
    logic [PW-1:0]      clr_page;
    logic [PW+IDX_W-1:0] slot_addr;

    always_comb begin
        case (r_level)
            2'd0:    lvl_idx = r_va[47:39];
            2'd1:    lvl_idx = r_va[38:30];
            2'd2:    lvl_idx = r_va[29:21];
            default: lvl_idx = r_va[20:12];
        endcase
    end

    assign base_pg = r_alloc_start[BASE_W-1:PG_SHIFT];

    // entry resolves to a pool page below the allocation mark
    assign diff_pg = i_ram_rdata[ENTRY_W-1:PG_SHIFT] - EPW'(base_pg);
    assign page_ok = (diff_pg < EPW'(r_next_page));

    assign new_pg   = APW'(base_pg) + APW'(r_next_page);
    assign end_pg   = new_pg + APW'(1);
    assign alloc_ok = (r_next_page < NPW'(POOL_PAGES))
                   && ({end_pg, {PG_SHIFT{1'b0}}} < CMPW'(r_mem_limit));
    assign new_entry = ENTRY_W'({new_pg, {PG_SHIFT{1'b0}}}) | ENTRY_W'(r_attr);

    assign clr_page  = i_cmd.clr_root ? '0 : r_next_page[PW-1:0];
    assign slot_addr = {r_cur, lvl_idx};

    always_comb begin
        o_ram_we    = i_cmd.wr_slot | i_cmd.wr_leaf | i_cmd.clr_wr;
        o_ram_waddr = slot_addr;
        o_ram_wdata = new_entry;
        if (i_cmd.clr_wr) begin
            o_ram_waddr = {clr_page, r_clr_idx};
            o_ram_wdata = '0;
        end else if (i_cmd.wr_leaf) begin
            o_ram_wdata = ENTRY_W'(r_pa) | ENTRY_W'(r_attr);
        end
    end

    assign o_ram_re    = i_cmd.rd;
    assign o_ram_raddr = slot_addr;

    always_comb begin
        o_stat.mode     = r_mode;
        o_stat.level    = r_level;
        o_stat.e_zero   = (i_ram_rdata == '0);
        o_stat.page_ok  = page_ok;
        o_stat.alloc_ok = alloc_ok;
        o_stat.clr_last = &r_clr_idx;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_start <= ALLOC_START_RST;
            r_mem_limit   <= MEM_LIMIT_RST;
            r_next_page   <= NPW'(1);
            r_clr_idx     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ALLOC_START: r_alloc_start <= i_cfg_data[BASE_W-1:0];
                    CFG_MEM_LIMIT:   r_mem_limit   <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_wr) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (i_cmd.alloc_adv) begin
                r_next_page <= r_next_page + NPW'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode  <= t_mode'(i_mode);
            r_va    <= i_virt_addr;
            r_pa    <= i_phys_addr;
            r_attr  <= i_attr;
            r_cur   <= '0;
            r_level <= LVL_TOP;
        end else if (i_cmd.advance) begin
            r_cur   <= diff_pg[PW-1:0];
            r_level <= r_level + 2'd1;
        end else if (i_cmd.alloc_adv) begin
            r_cur   <= r_next_page[PW-1:0];
            r_level <= r_level + 2'd1;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            if (r_mode == MODE_MAP) begin
                r_res_entry <= '0;
            end else if (i_cmd.res_status == ST_OK) begin
                r_res_entry <= i_ram_rdata;
            end else begin
                r_res_entry <= '1;
            end
        end
        if (i_cmd.push) begin
            r_out_entry  <= r_res_entry;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_entry  = r_out_entry;
    assign o_out_status = r_out_status;

endmodule

`default_nettype wire

// ===== rtl/core/page_table_map_and_walk_core.sv =====
`default_nettype none

// Four-level page-table engine over a pool of POOL_PAGES table pages of 512
// 64-bit entries each, held in one single-port-write, registered-read RAM.
// Map mode (mode 0) walks bits 47:39, 38:30, 29:21 of virt_addr from the root
// page, allocating and zero-filling a fresh pool page for each empty level,
// then writes phys_addr|attr into the leaf; lookup mode (mode 1) walks all
// four levels and returns the leaf entry, or all ones with status 1 when a
// level is empty or points outside the allocated pool. Status 2 means the
// pool or the memory limit is exhausted. One item is worked on at a time,
// with one RAM read and one check per level, and every page allocated is
// cleared one entry per cycle through the RAM write port before the walk
// goes on. After reset the root page is cleared the same way, and no input
// is taken until that is done; configuration writes are taken at any time
// but are meant only while the block is idle. A finished result waits in
// an output register while the next input is taken.
module page_table_map_and_walk_core
    import ptmw_pkg::*;
#(
    parameter int POOL_PAGES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ptmw_in_if.sink                   i_in,
    ptmw_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(POOL_PAGES) + IDX_W;

    t_cmd               cmd;
    t_stat              stat;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    ptmw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptmw_dpath #(
        .POOL_PAGES (POOL_PAGES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (i_in.mode),
        .i_virt_addr  (i_in.virt_addr),
        .i_phys_addr  (i_in.phys_addr),
        .i_attr       (i_in.attr),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_entry  (o_out.entry_value),
        .o_out_status (o_out.status)
    );

    ptmw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_PAGES * TBL_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ptmw_checker.sv =====
`default_nettype none

module ptmw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_out_entry,
    input wire logic [1:0]  i_out_status
);

    // result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a walk is running");

    // exhaustion only arises in map mode, which returns zero
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == 2'd2 |-> i_out_entry == 64'd0)
        else $error("exhausted status with non-zero entry");

    // not-mapped entry is zero in map mode or all ones in lookup
    a_nomap_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == 2'd1 |->
            (i_out_entry == 64'd0 || i_out_entry == {64{1'b1}}))
        else $error("not-mapped status with unexpected entry");

endmodule

bind page_table_map_and_walk_core ptmw_checker u_ptmw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_entry  (o_out.entry_value),
    .i_out_status (o_out.status)
);

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
    import ptmw_pkg::*;

    localparam int POOL_PAGES  = 64;
    localparam int STALL_LIMIT = 10000;
    localparam int PHASE_ITEMS = 190;

    typedef struct {
        logic [63:0] entry;
        t_status     st;
    } t_walk_result;

    // software copy of the table pool, the bump pointer and both registers
    class walk_scoreboard;
        int unsigned  pool_pages;
        logic [63:0]  tbl [];
        int unsigned  next_pg;
        logic [51:0]  alloc_start;
        logic [52:0]  mem_limit;
        t_walk_result walk_q [$];
        int           errors;
        int           n_items;
        int           n_ok;
        int           n_nomap;
        int           n_full;

        function new(int unsigned pages);
            pool_pages = pages;
            tbl = new[pages * TBL_ENTRIES];
            foreach (tbl[i]) tbl[i] = '0;
            next_pg     = 1;
            alloc_start = ALLOC_START_RST;
            mem_limit   = MEM_LIMIT_RST;
            errors      = 0;
            n_items     = 0;
            n_ok        = 0;
            n_nomap     = 0;
            n_full      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_ALLOC_START)
                alloc_start = data[BASE_W-1:0];
            else
                mem_limit = data[LIMIT_W-1:0];
        endfunction

        function int pending();
            return walk_q.size();
        endfunction

        // low 12 bits of the pool base are dropped
        function logic [63:0] base_addr();
            return {12'h0, alloc_start[51:12], 12'h0};
        endfunction

        function int unsigned slot(int unsigned pg, logic [47:0] va, int lvl);
            logic [47:0] sh;
            sh = va >> (PG_SHIFT + IDX_W * (LVL_LEAF - lvl));
            return pg * TBL_ENTRIES + sh[IDX_W-1:0];
        endfunction

        function bit page_from_entry(logic [63:0] e, output int unsigned pg);
            logic [63:0] off;
            logic [63:0] idx;
            off = {e[63:12], 12'h0} - base_addr();
            idx = off >> PG_SHIFT;
            if (idx >= next_pg || idx >= pool_pages)
                return 0;
            pg = idx[31:0];
            return 1;
        endfunction

        function bit take_page(output logic [63:0] addr);
            logic [63:0] a;
            int          i;
            if (next_pg >= pool_pages)
                return 0;
            a = base_addr() + (64'(next_pg) << PG_SHIFT);
            if (a + 64'd4096 >= 64'(mem_limit))
                return 0;
            for (i = 0; i < TBL_ENTRIES; i++)
                tbl[next_pg * TBL_ENTRIES + i] = '0;
            addr = a;
            next_pg++;
            return 1;
        endfunction

        function void note_input(logic mode, logic [47:0] va, logic [51:0] pa,
                                 logic [11:0] attr);
            t_walk_result x;
            int unsigned  cur;
            int unsigned  s;
            int           lvl;
            logic [63:0]  e;
            logic [63:0]  a;
            bit           done;
            cur     = 0;
            done    = 0;
            x.entry = '0;
            x.st    = ST_OK;
            n_items++;
            if (mode == MODE_MAP) begin
                for (lvl = LVL_TOP; lvl <= LVL_LAST_UPPER && !done; lvl++) begin
                    s = slot(cur, va, lvl);
                    e = tbl[s];
                    if (e == 0) begin
                        if (!take_page(a)) begin
                            x.st = ST_FULL;
                            done = 1;
                        end else begin
                            e = a | {52'h0, attr};
                            tbl[s] = e;
                        end
                    end
                    if (!done && !page_from_entry(e, cur)) begin
                        x.st = ST_NOMAP;
                        done = 1;
                    end
                end
                if (!done)
                    tbl[slot(cur, va, LVL_LEAF)] = {12'h0, pa} | {52'h0, attr};
            end else begin
                for (lvl = LVL_TOP; lvl <= LVL_LAST_UPPER && !done; lvl++) begin
                    e = tbl[slot(cur, va, lvl)];
                    if (e == 0 || !page_from_entry(e, cur)) begin
                        x.entry = '1;
                        x.st    = ST_NOMAP;
                        done    = 1;
                    end
                end
                if (!done)
                    x.entry = tbl[slot(cur, va, LVL_LEAF)];
            end
            walk_q.push_back(x);
        endfunction

        function void check_result(logic [63:0] ev, logic [1:0] st);
            t_walk_result x;
            if (walk_q.size() == 0) begin
                $error("result with no walk outstanding: entry_value %h status %0d", ev, st);
                errors++;
                return;
            end
            x = walk_q.pop_front();
            if (ev !== x.entry) begin
                $error("entry_value: expected %h, actual %h", x.entry, ev);
                errors++;
            end
            if (st !== x.st) begin
                $error("status: expected %0d, actual %0d", x.st, st);
                errors++;
            end
            case (x.st)
                ST_OK:    n_ok++;
                ST_NOMAP: n_nomap++;
                default:  n_full++;
            endcase
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ptmw_in_if  in_ch ();
    ptmw_out_if out_ch ();

    page_table_map_and_walk_core #(
        .POOL_PAGES(POOL_PAGES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    walk_scoreboard sb;
    int             idle_pct = 10;
    int             stall_cycles = 0;
    logic [47:0]    mapped_q [$];
    logic [8:0]     l0_set [4];
    logic [8:0]     l1_set [3];
    logic [8:0]     l2_set [3];

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.entry_value, out_ch.status);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("[page_table_map_and_walk_core] ERROR");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(logic mode, logic [47:0] va, logic [51:0] pa, logic [11:0] attr);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.virt_addr <= va;
        in_ch.phys_addr <= pa;
        in_ch.attr      <= attr;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sb.note_input(mode, va, pa, attr);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do
            @(negedge i_clk);
        while (sb.pending() != 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [47:0] path_va();
        return {l0_set[$urandom_range(3)], l1_set[$urandom_range(2)],
                l2_set[$urandom_range(2)], 9'($urandom), 12'($urandom)};
    endfunction

    // mostly maps and lookups over a few shared table paths, some noise
    task automatic run_phase(int n);
        int          k;
        int          r;
        logic        m;
        logic [47:0] va;
        logic [51:0] pa;
        logic [11:0] at;
        for (k = 0; k < n; k++) begin
            r  = $urandom_range(99);
            pa = 52'({$urandom, $urandom});
            at = 12'($urandom);
            if (r < 10) begin
                m  = 1'($urandom_range(1));
                va = 48'({$urandom, $urandom});
            end else if (r < 55) begin
                m  = MODE_MAP;
                va = path_va();
            end else begin
                m = MODE_LOOKUP;
                if (mapped_q.size() > 0 && $urandom_range(99) < 65)
                    va = mapped_q[$urandom_range(mapped_q.size() - 1)];
                else
                    va = path_va();
            end
            if (m == MODE_MAP)
                mapped_q.push_back(va);
            send_item(m, va, pa, at);
        end
        wait_idle();
    endtask

    initial begin
        logic [CFG_W-1:0] lim;
        sb              = new(POOL_PAGES);
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_ALLOC_START;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_MAP;
        in_ch.virt_addr = '0;
        in_ch.phys_addr = '0;
        in_ch.attr      = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        cfg_write(CFG_ALLOC_START, '0);
        cfg_write(CFG_MEM_LIMIT, 53'h10_0000_0000_0000);

        // empty root, first maps with all-ones and all-zero payloads
        send_item(MODE_LOOKUP, 48'h0, 52'h0, 12'h0);
        send_item(MODE_MAP, 48'h0, 52'hF_FFFF_FFFF_FFFF, 12'hFFF);
        send_item(MODE_LOOKUP, 48'h0, 52'h0, 12'h0);
        send_item(MODE_MAP, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h0);
        send_item(MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 12'hFFF);
        send_item(MODE_LOOKUP, 48'h0000_0000_1000, 52'h0, 12'h0);
        send_item(MODE_LOOKUP, 48'h0000_4000_0000, 52'h0, 12'h0);
        send_item(MODE_MAP, 48'h0000_0000_1000, 52'h1_2345_6789_A000, 12'h001);
        send_item(MODE_MAP, 48'h0, 52'h0_0000_0000_1000, 12'h800);
        send_item(MODE_LOOKUP, 48'h0000_0000_0ABC, 52'h0, 12'h0);
        send_item(MODE_LOOKUP, 48'h0000_0000_1FFF, 52'h0, 12'h0);
        send_item(MODE_MAP, 48'h0000_4000_0000, 52'hA_5A5A_5A5A_5000, 12'h5A5);
        send_item(MODE_LOOKUP, 48'h0000_4000_0000, 52'h0, 12'h0);
        wait_idle();

        // next page would end exactly at the limit
        cfg_write(CFG_MEM_LIMIT, CFG_W'((64'(sb.next_pg) + 1) << PG_SHIFT));
        send_item(MODE_MAP, 48'h0080_0000_0000, 52'h0_0000_0007_7000, 12'h003);
        send_item(MODE_LOOKUP, 48'h0080_0000_0000, 52'h0, 12'h0);
        wait_idle();
        // room for one page only: the upper level stays allocated
        cfg_write(CFG_MEM_LIMIT, CFG_W'(((64'(sb.next_pg) + 1) << PG_SHIFT) + 1));
        send_item(MODE_MAP, 48'h0080_0000_0000, 52'h0_0000_0007_7000, 12'h003);
        send_item(MODE_LOOKUP, 48'h0080_0000_0000, 52'h0, 12'h0);
        wait_idle();
        cfg_write(CFG_MEM_LIMIT, '0);
        send_item(MODE_MAP, 48'h0000_8000_0000, 52'h0_0000_0000_3000, 12'h010);
        send_item(MODE_MAP, 48'h0000_0000_2000, 52'h0_0000_0000_4000, 12'h020);
        wait_idle();
        cfg_write(CFG_MEM_LIMIT, 53'h10_0000_0000_0000);

        // unaligned base leaves old pointers stray
        cfg_write(CFG_ALLOC_START, 53'h5123);
        send_item(MODE_LOOKUP, 48'h0, 52'h0, 12'h0);
        send_item(MODE_MAP, 48'h0, 52'h0_0000_0000_9000, 12'h040);
        send_item(MODE_MAP, 48'h0100_0000_0000, 52'h5_5555_5555_5000, 12'h555);
        send_item(MODE_LOOKUP, 48'h0100_0000_0000, 52'h0, 12'h0);
        wait_idle();
        cfg_write(CFG_ALLOC_START, 53'hF_FFFF_FFFF_F000);
        send_item(MODE_MAP, 48'h0180_0000_0000, 52'h0_0000_0000_6000, 12'h0F0);
        send_item(MODE_LOOKUP, 48'h0100_0000_0000, 52'h0, 12'h0);
        wait_idle();

        l0_set = '{9'd0, 9'd511, 9'($urandom), 9'($urandom)};
        l1_set = '{9'd0, 9'($urandom), 9'd511};
        l2_set = '{9'd0, 9'($urandom), 9'($urandom)};

        cfg_write(CFG_ALLOC_START, '0);
        run_phase(PHASE_ITEMS);

        cfg_write(CFG_MEM_LIMIT, CFG_W'(((64'(sb.next_pg) + $urandom_range(1, 5)) << PG_SHIFT)
                                        + $urandom_range(4095)));
        run_phase(PHASE_ITEMS);

        cfg_write(CFG_MEM_LIMIT, 53'h10_0000_0000_0000);
        cfg_write(CFG_ALLOC_START, CFG_W'(($urandom_range(1, 6) << PG_SHIFT)
                                          | $urandom_range(4095)));
        run_phase(PHASE_ITEMS);

        // no idling on either side for this stretch
        idle_pct = 0;
        cfg_write(CFG_ALLOC_START, '0);
        run_phase(PHASE_ITEMS);
        idle_pct = 10;

        lim = CFG_W'({$urandom, $urandom});
        if (lim > 53'h10_0000_0000_0000)
            lim = lim >> 1;
        cfg_write(CFG_MEM_LIMIT, lim);
        cfg_write(CFG_ALLOC_START, CFG_W'(52'({$urandom, $urandom})));
        run_phase(PHASE_ITEMS);

        repeat (50) @(negedge i_clk);
        $display("%0d walks checked: %0d ok, %0d not mapped, %0d exhausted",
                 sb.n_items, sb.n_ok, sb.n_nomap, sb.n_full);
        $display("pool pages in use %0d of %0d, across base and limit changes",
                 sb.next_pg, POOL_PAGES);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[page_table_map_and_walk_core] OK");
        else
            $display("[page_table_map_and_walk_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
